>>> rtl/core/glyph_blit_page_framebuffer_unit_defines.svh
`ifndef GLYPH_BLIT_PAGE_FRAMEBUFFER_UNIT_DEFINES_SVH
`define GLYPH_BLIT_PAGE_FRAMEBUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define GBPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define GBPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gbpf_pkg.sv
`default_nettype none

package gbpf_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_WRITE,
        ST_CLEAR,
        ST_FETCH,
        ST_DONE
    } t_state;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [7:0] WIDTH_RST  = 8'd128;
    localparam logic [6:0] HEIGHT_RST = 7'd64;

    localparam logic signed [10:0] ADVANCE    = 11'sd6;
    localparam logic signed [10:0] CURSOR_MAX = 11'sd511;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_COUNT = 13;
    localparam logic [3:0] SLOT_BLANK = 4'd13;

    // Byte index width before the store-depth check (page <= 15, column <= 255)
    localparam int IDX_W = 12;

    // 5x7 glyphs, one column per entry, bit r is row r
    localparam logic [6:0] GLYPH_ROM [0:GLYPH_COUNT-1][0:GLYPH_COLS-1] = '{
        '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},  // 0
        '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},  // 1
        '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},  // 2
        '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},  // 3
        '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},  // 4
        '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},  // 5
        '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},  // 6
        '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},  // 7
        '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},  // 8
        '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},  // 9
        '{7'h00, 7'h36, 7'h36, 7'h00, 7'h00},  // colon
        '{7'h1E, 7'h21, 7'h41, 7'h41, 7'h22},  // C
        '{7'h62, 7'h64, 7'h08, 7'h13, 7'h23}   // percent
    };

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic sweep_step;
        logic calc;
        logic mem_read;
        logic mem_write;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic last_byte;
        logic out_free;
    } t_dp_stat;

    // Character code to ROM slot; blank slot for space and unknown codes
    function automatic logic [3:0] glyph_slot(input logic [7:0] code);
        logic [3:0] slot;
        slot = SLOT_BLANK;
        if (code >= 8'h30 && code <= 8'h39) begin
            slot = 4'(code - 8'h30);
        end else if (code == 8'h3A) begin
            slot = 4'd10;
        end else if (code == 8'h43) begin
            slot = 4'd11;
        end else if (code == 8'h25) begin
            slot = 4'd12;
        end
        return slot;
    endfunction

    function automatic logic [6:0] glyph_column(input logic [3:0] slot, input logic [2:0] col);
        logic [6:0] bits;
        bits = '0;
        if (slot < 4'(GLYPH_COUNT) && col < 3'(GLYPH_COLS)) begin
            bits = GLYPH_ROM[slot][col];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gbpf_ctrl.sv
`default_nettype none

module gbpf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire gbpf_pkg::t_cmd     i_req_cmd,
    output logic                    o_req_ready,
    input  wire gbpf_pkg::t_dp_stat i_stat,
    output gbpf_pkg::t_dp_cmd       o_cmd
);

    gbpf_pkg::t_state r_state, n_state;

    // State register; reset starts the store-clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbpf_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            gbpf_pkg::ST_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = gbpf_pkg::ST_IDLE;
                end
            end
            gbpf_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_item = 1'b1;
                    case (i_req_cmd)
                        gbpf_pkg::CMD_DRAW:  n_state = gbpf_pkg::ST_CALC;
                        gbpf_pkg::CMD_CLEAR: n_state = gbpf_pkg::ST_CLEAR;
                        gbpf_pkg::CMD_READ:  n_state = gbpf_pkg::ST_FETCH;
                        default:             n_state = gbpf_pkg::ST_DONE;
                    endcase
                end
            end
            gbpf_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = gbpf_pkg::ST_READ;
            end
            gbpf_pkg::ST_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = gbpf_pkg::ST_WRITE;
            end
            gbpf_pkg::ST_WRITE: begin
                o_cmd.mem_write = 1'b1;
                n_state = i_stat.last_byte ? gbpf_pkg::ST_DONE : gbpf_pkg::ST_CALC;
            end
            gbpf_pkg::ST_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = gbpf_pkg::ST_DONE;
                end
            end
            gbpf_pkg::ST_FETCH: begin
                o_cmd.mem_read = 1'b1;
                n_state        = gbpf_pkg::ST_DONE;
            end
            gbpf_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = gbpf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbpf_pkg::ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/gbpf_dp.sv
`default_nettype none

module gbpf_dp #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration writes
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [7:0]          i_cfg_data,
    // request fields
    input  wire gbpf_pkg::t_cmd      i_req_cmd,
    input  wire logic [7:0]          i_char_code,
    input  wire logic                i_start_of_string,
    input  wire logic signed [8:0]   i_x_pos,
    input  wire logic signed [7:0]   i_y_pos,
    input  wire logic [9:0]          i_read_index,
    // controller link
    input  wire gbpf_pkg::t_dp_cmd   i_cmd,
    output gbpf_pkg::t_dp_stat       o_stat,
    // result
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [7:0]               o_read_data
);

    localparam int DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 8;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers
    logic [7:0] r_width;
    logic [6:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gbpf_pkg::WIDTH_RST;
            r_height <= gbpf_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gbpf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                gbpf_pkg::CFG_HEIGHT: r_height <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Captured request and text cursor
    gbpf_pkg::t_cmd     r_cmd;
    logic [3:0]         r_slot;
    logic signed [9:0]  r_x;
    logic signed [7:0]  r_y;
    logic [AW-1:0]      r_ridx;
    logic               r_ridx_ok;
    logic signed [9:0]  r_cursor;

    logic signed [9:0]  x_sel;
    logic signed [10:0] x_adv;
    logic signed [9:0]  n_cursor;

    assign x_sel    = i_start_of_string ? {i_x_pos[8], i_x_pos} : r_cursor;
    assign x_adv    = {x_sel[9], x_sel} + gbpf_pkg::ADVANCE;
    assign n_cursor = (x_adv > gbpf_pkg::CURSOR_MAX) ? 10'sd511 : x_adv[9:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (i_cmd.load_item && i_req_cmd == gbpf_pkg::CMD_DRAW) begin
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd     <= i_req_cmd;
            r_slot    <= gbpf_pkg::glyph_slot(i_char_code);
            r_x       <= x_sel;
            r_y       <= i_y_pos;
            r_ridx    <= AW'(i_read_index);
            r_ridx_ok <= (32'(i_read_index) < DEPTH);
        end
    end

    // Byte walk: five columns, upper and lower page each
    logic [2:0] r_col;
    logic       r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_half <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_col  <= '0;
            r_half <= 1'b0;
        end else if (i_cmd.mem_write) begin
            if (r_half) begin
                r_col  <= r_col + 3'd1;
                r_half <= 1'b0;
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    // Pixel mask and byte address of the current byte
    localparam int IDX_W_L = gbpf_pkg::IDX_W;

    logic [6:0]         col_bits;
    logic [15:0]        col_shift;
    logic [7:0]         pix_bits;
    logic signed [5:0]  pg;
    logic signed [10:0] bx;
    logic               col_ok;
    logic [7:0]         row_ok;
    logic [7:0]         mask;
    logic [IDX_W_L-1:0] idx;

    always_comb begin
        col_bits  = gbpf_pkg::glyph_column(r_slot, r_col);
        col_shift = {9'b0, col_bits} << r_y[2:0];
        pix_bits  = r_half ? col_shift[15:8] : col_shift[7:0];
        pg        = {r_y[7], r_y[7:3]} + {5'b0, r_half};
        bx        = {r_x[9], r_x} + {8'b0, r_col};
        col_ok    = !bx[10] && (bx[9:0] < {2'b0, r_width});
        for (int b = 0; b < 8; b++) begin
            row_ok[b] = !pg[5] && ({pg[4:0], 3'(b)} < {1'b0, r_height});
        end
        mask = pix_bits & row_ok & {8{col_ok}};
        idx  = ({8'b0, pg[3:0]} * {4'b0, r_width}) + {4'b0, bx[7:0]};
    end

    logic [AW-1:0] r_addr;
    logic [7:0]    r_mask;
    logic          r_wen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_addr <= AW'(idx);
            r_mask <= mask;
            r_wen  <= (|mask) && (32'(idx) < DEPTH);
        end
    end

    // Clearing sweep counter
    logic [AW-1:0] r_sweep;
    logic          sweep_last;

    assign sweep_last = (r_sweep == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sweep <= sweep_last ? '0 : r_sweep + AW'(1);
        end
    end

    // Frame store: one write port, one registered read port
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] rd_addr;

    assign rd_addr = (r_cmd == gbpf_pkg::CMD_READ) ? r_ridx : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step) begin
            r_mem[r_sweep] <= '0;
        end else if (i_cmd.mem_write && r_wen) begin
            r_mem[r_addr] <= r_rdata | r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= (r_cmd == gbpf_pkg::CMD_READ && r_ridx_ok) ? r_rdata : 8'h00;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    assign o_stat.sweep_last = sweep_last;
    assign o_stat.last_byte  = (r_col == 3'(gbpf_pkg::GLYPH_COLS - 1)) && r_half;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> rtl/core/glyph_blit_page_framebuffer_unit.sv
`default_nettype none
// Channel   Direction  tdata (low bit up)                                tuser
// s_axis    in         char_code, start_of_string, x_pos, y_pos,         cmd
//                      read_index, zero pad to 40 bits
// m_axis    out        read_data                                         -
// cfg       in         i_cfg_index 0 panel_width, 1 panel_height         -
//
// One request at a time; a result waits in an output register while the next is taken.
// Draw: three steps per store byte (address/mask, read, write) over ten bytes.
// Read: goes through the registered store read port; an unused command goes straight to the result.
// Clear: one byte a cycle over the whole store (DEPTH = MAX_WIDTH * MAX_HEIGHT / 8).
// After reset the same sweep runs over all DEPTH bytes before s_axis_tready rises.
// A stalled m_axis holds the finished request in its last state until the result moves.

`include "glyph_blit_page_framebuffer_unit_defines.svh"

module glyph_blit_page_framebuffer_unit #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] char_code, [8] start_of_string, [17:9] x_pos, [25:18] y_pos,
    // [35:26] read_index, [39:36] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_data
    output logic [7:0]       m_axis_tdata
);

    gbpf_pkg::t_dp_cmd  w_cmd;
    gbpf_pkg::t_dp_stat w_stat;
    gbpf_pkg::t_cmd     req_cmd;

    assign req_cmd = gbpf_pkg::t_cmd'(s_axis_tuser);

    gbpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_cmd   (req_cmd),
        .o_req_ready (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    gbpf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_cmd         (req_cmd),
        .i_char_code       (s_axis_tdata[7:0]),
        .i_start_of_string (s_axis_tdata[8]),
        .i_x_pos           (s_axis_tdata[17:9]),
        .i_y_pos           (s_axis_tdata[25:18]),
        .i_read_index      (s_axis_tdata[35:26]),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_read_data       (m_axis_tdata)
    );

    // One request in flight: a taken request closes the input next cycle
    `GBPF_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another is in work")
    // No request is taken during a clearing sweep
    `GBPF_ASSERT_NOW(a_sweep_closed, i_clk, i_rst_n, w_cmd.sweep_step, !s_axis_tready, "input open during store sweep")
    // The sweep and the blit never write the store in the same cycle
    `GBPF_ASSERT_NOW(a_one_writer, i_clk, i_rst_n, w_cmd.mem_write, !w_cmd.sweep_step, "two store writers in one cycle")

endmodule

`default_nettype wire
